// ===== rtl/spfh_pkg.sv =====
`timescale 1ns / 1ps
package spfh_pkg;
  localparam int NODES_DEF = 64;
  localparam int NODE_W = 6;
  localparam int COST_W = 16;
  localparam int PCOST_W = 22;
  localparam int DIST_W = 23;
  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

  typedef enum logic [1:0] {
    ST_WRITE_DONE = 2'd0,
    ST_ROUTE      = 2'd1,
    ST_NO_ROUTE   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WR1, S_INIT, S_SEL, S_SEL_END, S_REL, S_REL_END,
    S_WALK, S_WALK_W, S_OUT
  } state_t;

  typedef struct packed {
    logic    valid;
    status_t status;
    logic [NODE_W-1:0] hop;
    logic [PCOST_W-1:0] cost;
  } result_t;
endpackage

// ===== rtl/spfh_edge_mem.sv =====
`timescale 1ns / 1ps
module spfh_edge_mem #(
  parameter int AW = 12
) (
  input  logic clk,
  input  logic we,
  input  logic [AW-1:0] waddr,
  input  logic [spfh_pkg::COST_W:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [spfh_pkg::COST_W:0] rdata
);
  import spfh_pkg::*;
  logic [COST_W:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/spfh_node_mem.sv =====
`timescale 1ns / 1ps
module spfh_node_mem #(
  parameter int NW = 6
) (
  input  logic clk,
  input  logic we,
  input  logic [NW-1:0] waddr,
  input  logic [spfh_pkg::DIST_W+NW-1:0] wdata,
  input  logic [NW-1:0] raddr,
  output logic [spfh_pkg::DIST_W+NW-1:0] rdata
);
  import spfh_pkg::*;
  logic [DIST_W+NW-1:0] mem [2**NW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/shortest_path_first_hop_core.sv =====
`timescale 1ns / 1ps
// Edge write: S_WR1 and S_WALK_W write both directions, then register the result.
// Query: paced by one read a cycle from the node and edge memories (scan and relax).
// One item in flight; next item taken once the result register is free.
// Reset: synchronous active-low; then a clearing pass over every edge entry
// with in_stall high meanwhile.
module shortest_path_first_hop_core #(
  parameter int NODES = spfh_pkg::NODES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_cmd,
  input  logic [5:0] in_node_a,
  input  logic [5:0] in_node_b,
  input  logic [15:0] in_edge_cost,
  input  logic in_edge_present,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] out_status,
  output logic [5:0] out_first_hop,
  output logic [21:0] out_path_cost
);
  import spfh_pkg::*;
  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int AW = 2 * NW;
  localparam int CW = NW + 1;

  state_t state_r, state_nxt;
  logic [AW:0] clr_r, clr_nxt;
  logic pres_r;
  logic [5:0] a_r, b_r;
  logic [COST_W-1:0] ecost_r;
  logic [CW-1:0] i_r, i_nxt;
  logic [NODES-1:0] settled_r, settled_nxt;
  logic [NW-1:0] u_r, u_nxt, walk_r, walk_nxt;
  logic [DIST_W-1:0] best_r, best_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  result_t res_r, res_nxt;

  logic e_we;
  logic [AW-1:0] e_waddr, e_raddr;
  logic [COST_W:0] e_wdata, e_rdata;
  logic n_we;
  logic [NW-1:0] n_waddr, n_raddr;
  logic [DIST_W+NW-1:0] n_wdata, n_rdata;
  logic [NW-1:0] rd_idx_r;
  logic rd_vld_r;

  spfh_edge_mem #(.AW(AW)) u_edge (.clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata));
  spfh_node_mem #(.NW(NW)) u_node (.clk, .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata));

  logic a_ok, b_ok;
  logic [NW-1:0] a_n, b_n, ix;
  logic [DIST_W-1:0] rd_dist, cand;
  logic [NW-1:0] rd_prev;

  assign a_ok = ({26'd0, a_r} < 32'(NODES));
  assign b_ok = ({26'd0, b_r} < 32'(NODES));
  assign a_n = NW'(a_r);
  assign b_n = NW'(b_r);
  assign ix = i_r[NW-1:0];
  assign rd_dist = n_rdata[DIST_W+NW-1:NW];
  assign rd_prev = n_rdata[NW-1:0];
  assign cand = best_r + {{(DIST_W-COST_W){1'b0}}, e_rdata[COST_W-1:0]};

  assign in_stall = (state_r != S_IDLE) || res_r.valid;
  assign out_valid = res_r.valid;
  assign out_status = res_r.status;
  assign out_first_hop = res_r.hop;
  assign out_path_cost = res_r.cost;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      res_r <= '0;
      settled_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      res_r <= res_nxt;
      settled_r <= settled_nxt;
      rd_vld_r <= (state_r == S_SEL || state_r == S_REL) && i_r < CW'(NODES);
    end
    rd_idx_r <= ix;
    i_r <= i_nxt;
    u_r <= u_nxt;
    best_r <= best_nxt;
    steps_r <= steps_nxt;
    walk_r <= walk_nxt;
    if (state_r == S_IDLE && in_valid && !in_stall) begin
      a_r <= in_node_a;
      b_r <= in_node_b;
      ecost_r <= in_edge_cost;
      pres_r <= in_edge_present;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    res_nxt = res_r;
    settled_nxt = settled_r;
    i_nxt = i_r;
    u_nxt = u_r;
    best_nxt = best_r;
    steps_nxt = steps_r;
    walk_nxt = walk_r;
    e_we = 1'b0;
    e_waddr = {a_n, b_n};
    e_wdata = pres_r ? {1'b1, ecost_r} : '0;
    e_raddr = {u_r, ix};
    n_we = 1'b0;
    n_waddr = ix;
    n_wdata = {DIST_INF, {NW{1'b0}}};
    n_raddr = ix;
    if (res_r.valid && !out_stall) res_nxt.valid = 1'b0;
    case (state_r)
      S_CLEAR: begin
        e_we = 1'b1;
        e_waddr = clr_r[AW-1:0];
        e_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(2**AW-1)) state_nxt = S_IDLE;
        if (clr_r >= (AW+1)'(2**AW)) begin
          e_we = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          i_nxt = '0;
          state_nxt = in_cmd ? S_INIT : S_WR1;
        end
      end
      S_WR1: begin
        if (a_ok && b_ok) begin
          e_we = 1'b1;
          e_waddr = {a_n, b_n};
        end
        state_nxt = S_WALK_W;
        steps_nxt = '0;
      end
      S_INIT: begin
        if (!a_ok || !b_ok || a_r == b_r) begin
          res_nxt = '{valid: 1'b1, status: ST_NO_ROUTE, hop: '0, cost: '0};
          state_nxt = S_IDLE;
        end else begin
          n_we = 1'b1;
          n_wdata = {(ix == a_n) ? '0 : DIST_INF, {NW{1'b0}}};
          i_nxt = i_r + 1'b1;
          if (i_r == CW'(NODES-1)) begin
            i_nxt = '0;
            settled_nxt = '0;
            best_nxt = DIST_INF;
            steps_nxt = '0;
            state_nxt = S_SEL;
          end
        end
      end
      S_SEL: begin
        if (rd_vld_r && !settled_r[rd_idx_r] && rd_dist < best_r) begin
          best_nxt = rd_dist;
          u_nxt = rd_idx_r;
        end
        if (i_r == CW'(NODES)) state_nxt = S_SEL_END;
        else i_nxt = i_r + 1'b1;
      end
      S_SEL_END: begin
        if (best_r == DIST_INF) begin
          res_nxt = '{valid: 1'b1, status: ST_NO_ROUTE, hop: '0, cost: '0};
          state_nxt = S_IDLE;
        end else begin
          settled_nxt[u_r] = 1'b1;
          if (u_r == b_n) begin
            walk_nxt = b_n;
            steps_nxt = '0;
            state_nxt = S_WALK;
          end else begin
            i_nxt = '0;
            state_nxt = S_REL;
          end
        end
      end
      S_REL: begin
        if (rd_vld_r && rd_idx_r != u_r && e_rdata[COST_W] && cand < rd_dist) begin
          n_we = 1'b1;
          n_waddr = rd_idx_r;
          n_wdata = {cand, u_r};
        end
        if (i_r == CW'(NODES)) state_nxt = S_REL_END;
        else i_nxt = i_r + 1'b1;
      end
      S_REL_END: begin
        steps_nxt = steps_r + 1'b1;
        i_nxt = '0;
        best_nxt = DIST_INF;
        state_nxt = (steps_r == CW'(NODES-1)) ? S_SEL_END : S_SEL;
        if (steps_r == CW'(NODES-1)) begin
          res_nxt = '{valid: 1'b1, status: ST_NO_ROUTE, hop: '0, cost: '0};
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        n_raddr = walk_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (walk_r == b_n && steps_r == '0) best_nxt = rd_dist;
        if (rd_prev == a_n) begin
          res_nxt = '{valid: 1'b1, status: ST_ROUTE, hop: 6'(walk_r),
                      cost: (walk_r == b_n && steps_r == '0) ? rd_dist[PCOST_W-1:0]
                                                           : best_r[PCOST_W-1:0]};
          state_nxt = S_IDLE;
        end else begin
          walk_nxt = rd_prev;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK_W: begin
        if (a_ok && b_ok) begin
          e_we = 1'b1;
          e_waddr = {b_n, a_n};
        end
        res_nxt = '{valid: 1'b1, status: ST_WRITE_DONE, hop: '0, cost: '0};
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import spfh_pkg::*;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
  localparam int N = 64;
  localparam int unsigned UNREACHED = 32'hffffffff;

  typedef struct {
    status_t     status;
    logic [5:0]  hop;
    logic [21:0] cost;
  } route_result_t;

  class route_scoreboard;
    logic [16:0]   edge_m[N][N];
    int unsigned   node_dist[N];
    int            prev[N];
    bit            settled[N];
    route_result_t awaited[$];
    int            failures;
    int            n_writes, n_found, n_none;

    function new();
      foreach (edge_m[i, j]) edge_m[i][j] = '0;
      foreach (node_dist[i]) begin
        node_dist[i] = 0;
        prev[i] = 0;
        settled[i] = 0;
      end
      failures = 0;
    endfunction

    function bit find_route(int src, int dst, output int hop, output int unsigned cost);
      int unsigned best, c;
      int u, n;
      hop = 0;
      cost = 0;
      if (src == dst) return 0;
      for (int i = 0; i < N; i++) begin
        node_dist[i] = UNREACHED;
        settled[i] = 0;
      end
      node_dist[src] = 0;
      for (int s = 0; s < N; s++) begin
        best = UNREACHED;
        u = 0;
        for (int i = 0; i < N; i++)
          if (!settled[i] && node_dist[i] < best) begin
            best = node_dist[i];
            u = i;
          end
        if (best == UNREACHED) break;
        settled[u] = 1;
        if (u == dst) break;
        for (int i = 0; i < N; i++)
          if (i != u && edge_m[u][i][16]) begin
            c = best + edge_m[u][i][15:0];
            if (c < node_dist[i]) begin
              node_dist[i] = c;
              prev[i] = u;
            end
          end
      end
      if (!settled[dst]) return 0;
      n = dst;
      for (int s = 0; s < N; s++) begin
        if (prev[n] == src) break;
        n = prev[n];
      end
      hop = n;
      cost = node_dist[dst];
      return 1;
    endfunction

    function void note_input(logic cmd, logic [5:0] a, logic [5:0] b, logic [15:0] ec,
                             logic ep);
      route_result_t r;
      int hop;
      int unsigned cost;
      r.status = ST_WRITE_DONE;
      r.hop = '0;
      r.cost = '0;
      if (cmd == CMD_WRITE) begin
        edge_m[a][b] = ep ? {1'b1, ec} : 17'd0;
        edge_m[b][a] = ep ? {1'b1, ec} : 17'd0;
        n_writes++;
      end else if (find_route(a, b, hop, cost)) begin
        r.status = ST_ROUTE;
        r.hop = hop[5:0];
        r.cost = cost[21:0];
        n_found++;
      end else begin
        r.status = ST_NO_ROUTE;
        n_none++;
      end
      awaited.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [5:0] hop, logic [21:0] cost);
      route_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result status=%0d hop=%0d cost=%0d",
                 $time, st, hop, cost);
        failures++;
        return;
      end
      e = awaited.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        failures++;
      end
      if (hop !== e.hop) begin
        $display("%0t: first_hop expected %0d actual %0d", $time, e.hop, hop);
        failures++;
      end
      if (cost !== e.cost) begin
        $display("%0t: path_cost expected %0d actual %0d", $time, e.cost, cost);
        failures++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_cmd = 0;
  logic [5:0] in_node_a = 0;
  logic [5:0] in_node_b = 0;
  logic [15:0] in_edge_cost = 0;
  logic in_edge_present = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] out_status;
  logic [5:0] out_first_hop;
  logic [21:0] out_path_cost;

  route_scoreboard sb = new();
  bit idle_on = 1;
  int sent = 0;

  shortest_path_first_hop_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_node_a(in_node_a), .in_node_b(in_node_b),
    .in_edge_cost(in_edge_cost), .in_edge_present(in_edge_present),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_first_hop(out_first_hop),
    .out_path_cost(out_path_cost)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #100_000_000;
    $display("shortest_path_first_hop_core regression: fail");
    $finish;
  end

  // result side
  initial forever begin
    @(negedge clk);
    out_stall = idle_on && ($urandom_range(0, 99) < 28);
    @(posedge clk);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_first_hop, out_path_cost);
  end

  task automatic send(logic cmd, logic [5:0] a, logic [5:0] b, logic [15:0] ec, logic ep);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 28) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_cmd = cmd;
    in_node_a = a;
    in_node_b = b;
    in_edge_cost = ec;
    in_edge_present = ep;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(cmd, a, b, ec, ep);
    sent++;
  endtask

  task automatic link(int a, int b, int c);
    send(CMD_WRITE, a[5:0], b[5:0], c[15:0], 1'b1);
  endtask

  task automatic ask(int a, int b);
    send(CMD_QUERY, a[5:0], b[5:0], 16'($urandom), 1'($urandom));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    int base, k, a, b, c;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed
    link(0, 63, 16'hffff);
    link(63, 62, 0);
    ask(0, 62);
    ask(62, 0);
    link(5, 5, 16'h1234);
    ask(5, 5);
    ask(1, 40);
    link(10, 11, 5);
    link(10, 12, 5);
    link(11, 13, 5);
    link(12, 13, 5);
    ask(10, 13);
    ask(13, 10);
    send(CMD_WRITE, 6'd11, 6'd13, 16'hffff, 1'b0);
    ask(10, 13);
    link(20, 21, 16'haaaa);
    link(21, 22, 16'h5555);
    link(20, 22, 16'hffff);
    ask(20, 22);
    send(CMD_WRITE, 6'd0, 6'd63, 16'd7, 1'b0);
    ask(0, 62);
    drain();

    // random graphs; long stretch without idling first
    idle_on = 0;
    while (sent < 140) begin
      if (sent > 60) idle_on = 1;
      if (sent > 100 && sent < 105) drain();
      if ($urandom_range(0, 9) == 0) begin
        send(1'($urandom), 6'($urandom), 6'($urandom), 16'($urandom), 1'($urandom));
        continue;
      end
      k = $urandom_range(4, 12);
      base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63 - k) : $urandom_range(0, 8);
      repeat ($urandom_range(3, 8)) begin
        a = base + $urandom_range(0, k - 1);
        b = base + $urandom_range(0, k - 1);
        c = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
        send(CMD_WRITE, a[5:0], b[5:0], c[15:0], $urandom_range(0, 99) >= 15);
      end
      repeat ($urandom_range(1, 3))
        ask(base + $urandom_range(0, k - 1), base + $urandom_range(0, k - 1));
    end
    drain();
    repeat (20000) @(posedge clk);

    $display("covered %0d transfers: %0d edge writes, %0d routes found, %0d without route",
             sent, sb.n_writes, sb.n_found, sb.n_none);
    if (sb.failures == 0 && sb.awaited.size() == 0) begin
      $display("shortest_path_first_hop_core regression: pass");
    end else begin
      $display("shortest_path_first_hop_core regression: fail");
    end
    $finish;
  end
endmodule
